FILE: design/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg: shared types and constants for the vector to polar angle pipeline
// Stage counts, datapath widths, angle constants and the CORDIC step table.
// ----------------------------------------------------------------------------
`default_nettype none

package vpa_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int ROT_STEPS    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  // Square root: one result bit per stage, then a rounding stage.
  localparam int ROOT_BITS = 32;
  localparam int SQRT_LAT  = ROOT_BITS + 1;

  // CORDIC: pre-rotation, normalize, rotations, two fold stages.
  localparam int NORM_LAT   = 5;
  localparam int CORDIC_LAT = 1 + NORM_LAT + ROT_STEPS + 2;

  localparam int OPW   = 34;  // pre-rotated / normalized operand width
  localparam int AW    = 37;  // rotation datapath width
  localparam int ANG_W = 36;  // angle accumulator width, 2^-24 degree

  localparam logic signed [ANG_W-1:0] DEG180 = 36'sd3019898880;
  localparam logic signed [ANG_W-1:0] DEG360 = 36'sd6039797760;

  localparam logic [24:0] OUT_CIRCLE = 25'd23592960;
  localparam logic [24:0] OUT_DEG90  = 25'd5898240;
  localparam logic [24:0] OUT_DEG270 = 25'd17694720;

  typedef struct packed {
    logic               vert;
    logic               z_pos;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vpa_side_t;

  typedef struct packed {
    logic        vert;
    logic        z_pos;
    logic [31:0] mag;
  } vpa_post_t;

  // Bit-serial long division, used only for constant tables.
  function automatic logic [63:0] div_floor(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-k) in units of 2^-24 degree.
  function automatic logic [31:0] step_angle(input int k);
    logic signed [63:0] acc;
    logic signed [63:0] term;
    logic        [63:0] rad32;
    logic        [63:0] prod;
    int                 e;
    acc = '0;
    if (k == 0) begin
      return 32'd754974720;
    end
    for (int j = 0; j < 32; j++) begin
      e = 62 - (2 * j + 1) * k;
      if (e >= 0) begin
        term = signed'(div_floor(64'd1 << e, 64'(2 * j + 1)));
        if (j[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    rad32 = unsigned'((acc + 64'sd536870912) >>> 30);
    prod  = rad32 * 64'd961263669 + 64'd2147483648;
    return prod[63:32];
  endfunction

endpackage

`default_nettype wire

FILE: design/vector_to_polar_angles.sv
// ----------------------------------------------------------------------------
// vector_to_polar_angles: length, yaw and pitch of a signed Q16.16 3D vector
// Fully pipelined; one vector per cycle, with a global stall on the output.
// ----------------------------------------------------------------------------
// Each word accepted on the input carries one vector (vec_x, vec_y, vec_z)
// and yields exactly one result word: the rounded Euclidean length, the yaw
// atan2(y, x) and the pitch atan2(z, horizontal length), both in 1/65536
// degree folded into [0, 360). A vector with x = y = 0 reports yaw 0, pitch
// 90 (z > 0) or 270 degrees, and raises vertical_axis. The block accepts a
// new word every cycle unless a finished word waits on out_ready, which
// holds the whole pipeline. Words pass the square root (one root bit per
// stage over 32 stages, then a rounding stage), the CORDIC with one
// micro-rotation per stage, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_to_polar_angles (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [31:0] magnitude,
  output logic        [24:0] yaw_angle,
  output logic        [24:0] pitch_angle,
  output logic               vertical_axis
);
  import vpa_pkg::*;

  localparam int SQ_OUT = 3 + SQRT_LAT;     // valid index at the root outputs
  localparam int LAST   = SQ_OUT + CORDIC_LAT;

  // Advance every stage when the output register is free or being taken.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic vld [LAST+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i <= LAST; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Stage A: capture the vector.
  logic signed [31:0] xa;
  logic signed [31:0] ya;
  logic signed [31:0] za;

  always_ff @(posedge clk) begin
    if (adv) begin
      xa <= vec_x;
      ya <= vec_y;
      za <= vec_z;
    end
  end

  // Stage B: squares of the magnitudes.
  logic [31:0] abs_x;
  logic [31:0] abs_y;
  logic [31:0] abs_z;
  logic [63:0] sqx;
  logic [63:0] sqy;
  logic [63:0] sqz;
  vpa_side_t   side_b;

  assign abs_x = xa[31] ? 32'(-xa) : xa;
  assign abs_y = ya[31] ? 32'(-ya) : ya;
  assign abs_z = za[31] ? 32'(-za) : za;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx          <= abs_x * abs_x;
      sqy          <= abs_y * abs_y;
      sqz          <= abs_z * abs_z;
      side_b.vert  <= (xa == 0) && (ya == 0);
      side_b.z_pos <= za > 0;
      side_b.x     <= xa;
      side_b.y     <= ya;
      side_b.z     <= za;
    end
  end

  // Stage C: horizontal square sum. Stage D: full square sum.
  logic [63:0] horiz_c;
  logic [63:0] sqz_c;
  vpa_side_t   side_c;
  logic [63:0] horiz_d;
  logic [63:0] full_d;
  vpa_side_t   side_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      horiz_c <= sqx + sqy;
      sqz_c   <= sqz;
      side_c  <= side_b;
      horiz_d <= horiz_c;
      full_d  <= horiz_c + sqz_c;
      side_d  <= side_c;
    end
  end

  // Square roots of both sums, side data delayed to match.
  logic [31:0] fwd;
  logic [31:0] mag;
  vpa_side_t   side_dly [SQRT_LAT];

  vpa_sqrt u_sqrt_horiz (
    .clk  (clk),
    .en   (adv),
    .rad  (horiz_d),
    .root (fwd)
  );

  vpa_sqrt u_sqrt_full (
    .clk  (clk),
    .en   (adv),
    .rad  (full_d),
    .root (mag)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dly[0] <= side_d;
      for (int i = 1; i < SQRT_LAT; i++) begin
        side_dly[i] <= side_dly[i-1];
      end
    end
  end

  // Both angles through matched CORDIC pipelines.
  vpa_side_t   side_e;
  logic [24:0] yaw;
  logic [24:0] pitch;
  vpa_post_t   post_dly [CORDIC_LAT];

  assign side_e = side_dly[SQRT_LAT-1];

  vpa_cordic u_cordic_yaw (
    .clk   (clk),
    .en    (adv),
    .a_in  (33'(side_e.x)),
    .b_in  (33'(side_e.y)),
    .angle (yaw)
  );

  vpa_cordic u_cordic_pitch (
    .clk   (clk),
    .en    (adv),
    .a_in  ({1'b0, fwd}),
    .b_in  (33'(side_e.z)),
    .angle (pitch)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      post_dly[0].vert  <= side_e.vert;
      post_dly[0].z_pos <= side_e.z_pos;
      post_dly[0].mag   <= mag;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        post_dly[i] <= post_dly[i-1];
      end
    end
  end

  // Output register; substitute the fixed angles for a vertical vector.
  vpa_post_t post_f;
  assign post_f = post_dly[CORDIC_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      magnitude     <= post_f.mag;
      vertical_axis <= post_f.vert;
      if (post_f.vert) begin
        yaw_angle   <= '0;
        pitch_angle <= post_f.z_pos ? OUT_DEG90 : OUT_DEG270;
      end else begin
        yaw_angle   <= yaw;
        pitch_angle <= pitch;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input held off without a waiting output word");

  a_last_moves: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[LAST]) |=> out_valid)
    else $error("finished word lost before the output register");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((yaw_angle < OUT_CIRCLE) && (pitch_angle < OUT_CIRCLE)))
    else $error("angle out of [0, 360)");

  a_vertical_yaw: assert property (@(posedge clk) disable iff (rst)
    (out_valid && vertical_axis) |-> (yaw_angle == '0))
    else $error("vertical vector with nonzero yaw");
`endif

endmodule

`default_nettype wire

FILE: design/vpa_sqrt.sv
// ----------------------------------------------------------------------------
// vpa_sqrt: pipelined integer square root, rounded to nearest
// One root bit per stage over the 64-bit radicand, then a rounding stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import vpa_pkg::*;

  logic [63:0] rem  [ROOT_BITS];
  logic [63:0] part [ROOT_BITS];
  logic [32:0] rounded;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] s_in;
    logic [63:0] r_in;
    logic [63:0] trial;
    logic [63:0] rem_next;
    logic [63:0] part_next;

    if (i == 0) begin : g_first
      assign s_in = rad;
      assign r_in = '0;
    end else begin : g_rest
      assign s_in = rem[i-1];
      assign r_in = part[i-1];
    end

    always_comb begin
      trial = r_in + BIT;
      if (s_in >= trial) begin
        rem_next  = s_in - trial;
        part_next = (r_in >> 1) + BIT;
      end else begin
        rem_next  = s_in;
        part_next = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= rem_next;
        part[i] <= part_next;
      end
    end
  end

  // Round up when the remainder exceeds the floor root.
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem[ROOT_BITS-1] > part[ROOT_BITS-1]) begin
        rounded <= part[ROOT_BITS-1][32:0] + 33'd1;
      end else begin
        rounded <= part[ROOT_BITS-1][32:0];
      end
    end
  end

  assign root = rounded[32] ? 32'hFFFF_FFFF : rounded[31:0];

endmodule

`default_nettype wire

FILE: design/vpa_cordic.sv
// ----------------------------------------------------------------------------
// vpa_cordic: pipelined vectoring CORDIC, atan2(b, a) folded to [0, 360)
// Pre-rotation, staged normalize shift, one micro-rotation per stage, fold.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] a_in,
  input  logic signed [32:0] b_in,
  output logic        [24:0] angle
);
  import vpa_pkg::*;

  // Pre-rotation into the right half plane.
  logic signed [OPW-1:0]   pa;
  logic signed [OPW-1:0]   pb;
  logic        [32:0]      pm;
  logic signed [ANG_W-1:0] pang;

  logic signed [OPW-1:0]   a_ext;
  logic signed [OPW-1:0]   b_ext;
  logic signed [OPW-1:0]   a_pre;
  logic signed [OPW-1:0]   b_pre;
  logic        [32:0]      ma;
  logic        [32:0]      mb;

  always_comb begin
    a_ext = OPW'(a_in);
    b_ext = OPW'(b_in);
    if (a_ext < 0) begin
      a_pre = -a_ext;
      b_pre = -b_ext;
    end else begin
      a_pre = a_ext;
      b_pre = b_ext;
    end
    ma = a_pre[OPW-1] ? 33'(-a_pre) : a_pre[32:0];
    mb = b_pre[OPW-1] ? 33'(-b_pre) : b_pre[32:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= a_pre;
      pb <= b_pre;
      pm <= (ma > mb) ? ma : mb;
      if (a_ext < 0) begin
        pang <= (b_ext >= 0) ? DEG180 : -DEG180;
      end else begin
        pang <= '0;
      end
    end
  end

  // Normalize: shift by 16, 8, 4, 2, 1 while the top bits are clear.
  logic signed [OPW-1:0]   na   [NORM_LAT];
  logic signed [OPW-1:0]   nb   [NORM_LAT];
  logic        [32:0]      nm   [NORM_LAT];
  logic signed [ANG_W-1:0] nang [NORM_LAT];

  for (genvar j = 0; j < NORM_LAT; j++) begin : g_norm
    localparam int SH = 16 >> j;
    logic signed [OPW-1:0]   a_i;
    logic signed [OPW-1:0]   b_i;
    logic        [32:0]      m_i;
    logic signed [ANG_W-1:0] g_i;

    if (j == 0) begin : g_first
      assign a_i = pa;
      assign b_i = pb;
      assign m_i = pm;
      assign g_i = pang;
    end else begin : g_rest
      assign a_i = na[j-1];
      assign b_i = nb[j-1];
      assign m_i = nm[j-1];
      assign g_i = nang[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nang[j] <= g_i;
        if (m_i[31 -: SH] == '0) begin
          na[j] <= a_i <<< SH;
          nb[j] <= b_i <<< SH;
          nm[j] <= m_i << SH;
        end else begin
          na[j] <= a_i;
          nb[j] <= b_i;
          nm[j] <= m_i;
        end
      end
    end
  end

  // Micro-rotations, one per stage.
  logic signed [AW-1:0]    ra   [ROT_STEPS];
  logic signed [AW-1:0]    rb   [ROT_STEPS];
  logic signed [ANG_W-1:0] rang [ROT_STEPS];

  for (genvar k = 0; k < ROT_STEPS; k++) begin : g_rot
    localparam logic signed [ANG_W-1:0] STEP = ANG_W'(step_angle(k));
    logic signed [AW-1:0]    a_i;
    logic signed [AW-1:0]    b_i;
    logic signed [ANG_W-1:0] g_i;

    if (k == 0) begin : g_first
      assign a_i = AW'(na[NORM_LAT-1]);
      assign b_i = AW'(nb[NORM_LAT-1]);
      assign g_i = nang[NORM_LAT-1];
    end else begin : g_rest
      assign a_i = ra[k-1];
      assign b_i = rb[k-1];
      assign g_i = rang[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (b_i >= 0) begin
          ra[k]   <= a_i + (b_i >>> k);
          rb[k]   <= b_i - (a_i >>> k);
          rang[k] <= g_i + STEP;
        end else begin
          ra[k]   <= a_i - (b_i >>> k);
          rb[k]   <= b_i + (a_i >>> k);
          rang[k] <= g_i - STEP;
        end
      end
    end
  end

  // Fold: add a full circle to negative angles, then round and wrap.
  logic [ANG_W-2:0]        fpos;
  logic signed [ANG_W-1:0] fsum;
  logic [ANG_W-2:0]        rnd;
  logic [ANG_W-2:0]        wrapped;
  logic [24:0]             fout;

  always_comb begin
    if (rang[ROT_STEPS-1] < 0) begin
      fsum = rang[ROT_STEPS-1] + DEG360;
    end else begin
      fsum = rang[ROT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fpos <= (fsum < 0) ? '0 : fsum[ANG_W-2:0];
    end
  end

  always_comb begin
    rnd = (fpos + (ANG_W-1)'(128)) >> 8;
    if (rnd >= (ANG_W-1)'(OUT_CIRCLE)) begin
      wrapped = rnd - (ANG_W-1)'(OUT_CIRCLE);
    end else begin
      wrapped = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fout <= (wrapped >= (ANG_W-1)'(OUT_CIRCLE)) ? '0 : wrapped[24:0];
    end
  end

  assign angle = fout;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector_to_polar_angles
// Drives signed vectors over valid/ready, predicts length, yaw, pitch and the
// vertical flag with an independent CORDIC model, and checks every result word
// in order under several idle and stall patterns.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [31:0] mag;
  logic [24:0] yaw;
  logic [24:0] pitch;
  logic        vert;
} polar_t;

class polar_scoreboard;
  polar_t      pending[$];
  int          errors;
  int          checked;
  longint      step_tab[32];

  function new();
    for (int k = 0; k < 32; k++) step_tab[k] = atan_step(k);
  endfunction

  // atan(2^-k) in 2^-24 degree, built from a Taylor series in Q62 radians
  static function longint atan_step(int k);
    longint acc, term, rad;
    int e;
    acc = 0;
    if (k == 0) return longint'(45) << 24;
    for (int j = 0; j < 40; j++) begin
      e = 62 - (2 * j + 1) * k;
      if (e < 0) break;
      term = (longint'(1) << e) / (2 * j + 1);
      acc = j[0] ? acc - term : acc + term;
    end
    rad = (acc + (longint'(1) << 29)) >>> 30;
    return longint'((longint'(unsigned'(rad)) * 64'd961263669 + 64'd2147483648) >> 32);
  endfunction

  static function logic [63:0] isqrt_round(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (s > r) r++;
    return r;
  endfunction

  function longint vector_angle(longint a, longint b);
    longint ang, da, db;
    longint unsigned m;
    int sh;
    ang = 0;
    sh = 0;
    if (a == 0 && b == 0) return 0;
    if (a < 0) begin
      ang = (b >= 0) ? (longint'(180) << 24) : -(longint'(180) << 24);
      a = -a;
      b = -b;
    end
    m = (a > (b < 0 ? -b : b)) ? a : (b < 0 ? -b : b);
    while (m < (64'd1 << 31)) begin
      m <<= 1;
      sh++;
    end
    a = a <<< sh;
    b = b <<< sh;
    for (int k = 0; k < 24; k++) begin
      da = b >>> k;
      db = a >>> k;
      if (b >= 0) begin
        a += da; b -= db; ang += step_tab[k];
      end else begin
        a -= da; b += db; ang -= step_tab[k];
      end
    end
    return ang;
  endfunction

  static function logic [24:0] fold_deg(longint ang);
    longint r;
    if (ang < 0) ang += longint'(360) << 24;
    if (ang < 0) ang = 0;
    r = (ang + 128) >>> 8;
    if (r >= 23592960) r -= 23592960;
    if (r >= 23592960) r = 0;
    return r[24:0];
  endfunction

  // note an accepted input word and queue its expected result
  function void note_vector(logic signed [31:0] x, y, z);
    longint xl, yl, zl;
    logic [63:0] h2, m;
    polar_t p;
    xl = x; yl = y; zl = z;
    h2 = xl * xl + yl * yl;
    m = isqrt_round(h2 + zl * zl);
    p.mag = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
    if (x == 0 && y == 0) begin
      p.vert = 1'b1;
      p.yaw = '0;
      p.pitch = (z > 0) ? 25'd5898240 : 25'd17694720;
    end else begin
      p.vert = 1'b0;
      p.yaw = fold_deg(vector_angle(xl, yl));
      p.pitch = fold_deg(vector_angle(longint'(isqrt_round(h2)), zl));
    end
    pending.push_back(p);
  endfunction

  function void check_result(polar_t got);
    polar_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word: %p", got);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("mismatch #%0d: mag %h/%h yaw %0d/%0d pitch %0d/%0d vert %b/%b (exp/act)",
                 checked, want.mag, got.mag, want.yaw, got.yaw, want.pitch, got.pitch,
                 want.vert, got.vert);
    end
  endfunction
endclass

module testbench;
  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] vec_x, vec_y, vec_z;
  logic [31:0] magnitude;
  logic [24:0] yaw_angle, pitch_angle;
  logic vertical_axis;

  polar_scoreboard scb;
  int send_idle_pct;   // chance in a hundred that the sender idles a cycle
  int recv_stall_pct;  // chance in a hundred that the receiver stalls a cycle
  int sent;

  vector_to_polar_angles u_top (
    .clk, .rst, .in_valid, .in_ready, .vec_x, .vec_y, .vec_z,
    .out_valid, .out_ready, .magnitude, .yaw_angle, .pitch_angle, .vertical_axis
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit: far above the slowest legal run (~1400 words at heavy stall).
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: stall at random, sample on the rising edge, drive on the falling.
  always @(negedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      scb.check_result('{magnitude, yaw_angle, pitch_angle, vertical_axis});
  end

  // Send one word: optional idle gap, then hold valid until accepted.
  // Valid stays high after acceptance so that words can follow back to back.
  task automatic send_vector(logic signed [31:0] x, y, z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    do @(posedge clk); while (!in_ready);
    scb.note_vector(x, y, z);
    sent++;
    @(negedge clk);
  endtask

  // Wide random component; often small or extreme so all regions are hit.
  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $urandom_range(3) == 0 ? 0 : $signed($urandom) >>> $urandom_range(31);
      3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom) >>> $urandom_range(20);
    endcase
  endfunction

  // Drop valid and hold off until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (scb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic signed [31:0] rx, ry;
    scb = new();
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    vec_x = '0; vec_y = '0; vec_z = '0;
    out_ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: vertical vectors, axis extremes and quadrant boundaries.
    send_vector(0, 0, 0);
    send_vector(0, 0, 32'sh0001_0000);
    send_vector(0, 0, -32'sh0001_0000);
    send_vector(0, 0, 32'sh7FFF_FFFF);
    send_vector(0, 0, 32'sh8000_0000);
    send_vector(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_vector(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_vector(32'sh8000_0000, 0, 0);
    send_vector(-1, 0, 0);        // negative x, zero y: half-turn pre-rotation
    send_vector(-1, -1, 1);
    send_vector(-1, 1, -1);
    send_vector(1, 0, 0);
    send_vector(0, 1, 0);
    send_vector(0, -1, 0);
    send_vector(1, -1, 0);        // negative angle: yaw folds to 315 degrees
    send_vector(32'sh7FFF_FFFF, -1, -1);
    send_vector(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    send_vector(32'sh7FFF_FFFF, 0, -1);
    send_vector(-32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_vector(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);

    // Hold off until the pipeline is empty, then random phases.
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      repeat (345) begin
        rx = rand_comp();
        ry = rand_comp();
        if ($urandom_range(15) == 0) begin rx = 0; ry = 0; end
        send_vector(rx, ry, rand_comp());
      end
    end

    drain();
    repeat (100) @(negedge clk);
    $display("covered %0d vectors (%0d results checked) across four idle/stall mixes",
             sent, scb.checked);
    if (scb.errors == 0 && scb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", scb.errors);
      $display("status: fail");
    end
    $finish;
  end
endmodule
